>>> hw/rtl/dtfp_pkg.sv
// Shared types, constants and helpers for the dual target frame parser.
package dtfp_pkg;

  localparam int MAX_FRAME_BYTES = 7;
  localparam int CNT_W           = $clog2(MAX_FRAME_BYTES + 1);
  localparam int DATA_BYTES      = 4;
  localparam int KEPT_BYTES      = 5;

  localparam logic [7:0] SYNC_BYTE = 8'hFE;
  localparam logic [7:0] TERM_BYTE = 8'hFF;

  localparam logic [15:0] TIMEOUT_RST     = 16'd100;
  localparam logic [7:0]  X_CENTER_RST    = 8'd80;
  localparam logic [7:0]  Y_CENTER_RST    = 8'd60;
  localparam logic [7:0]  ABSENT_CODE_RST = 8'd253;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TIMEOUT  = 2'd0,
    CFG_X_CENTER = 2'd1,
    CFG_Y_CENTER = 2'd2,
    CFG_ABSENT   = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_SUM     = 2'd1,
    ST_NOTERM  = 2'd2,
    ST_TIMEOUT = 2'd3
  } status_e;

  // What the front hands to the back for each finished frame or timeout.
  typedef enum logic [1:0] {
    EV_TIMEOUT = 2'd0,
    EV_NOTERM  = 2'd1,
    EV_SHORT   = 2'd2,
    EV_FRAME   = 2'd3
  } ev_kind_e;

  typedef struct packed {
    ev_kind_e                        kind;
    logic [KEPT_BYTES-1:0][7:0]      bytes;
  } ev_t;

  typedef struct packed {
    logic [7:0] x_center;
    logic [7:0] y_center;
    logic [7:0] absent_code;
  } back_cfg_t;

  typedef struct packed {
    status_e           status;
    logic              black_valid;
    logic signed [8:0] black_x;
    logic signed [8:0] black_y;
    logic              car_valid;
    logic signed [8:0] car_x;
    logic signed [8:0] car_y;
  } res_t;

  // Byte modulo 10 by restoring subtraction of 160, 80, 40, 20, 10.
  function automatic logic [3:0] mod10(input logic [7:0] v);
    logic [7:0] r;
    r = v;
    if (r >= 8'd160) r = r - 8'd160;
    if (r >= 8'd80)  r = r - 8'd80;
    if (r >= 8'd40)  r = r - 8'd40;
    if (r >= 8'd20)  r = r - 8'd20;
    if (r >= 8'd10)  r = r - 8'd10;
    return r[3:0];
  endfunction

endpackage

>>> hw/rtl/dual_target_frame_parser_unit.sv
// Top level of the dual target frame parser: config registers, front, queue, back.
//
//  channel   dir   handshake                  beat carries
//  -------   ---   -------------------------  --------------------------------------
//  item      in    push / full                mode_i, rx_byte_i
//  result    out   empty / pop                status_o, black_*_o, car_*_o
//  config    in    cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
//  One item beat per cycle unless full. The front classifies a beat in the cycle it
//  is taken; a frame end or timeout becomes an event in a 2-beat queue, and the back
//  takes one event per cycle while the result queue has room, computes the checksum
//  and updates the targets. A result is registered in the event queue, then in the
//  result queue, before it shows on the ports and can be popped.
//  Reset clears control and target state at once; there is no clearing pass.
//  If pop is held low the 2-beat result queue fills, then the event queue, then
//  full rises; items that cause no result are also held off while full is high.
module dual_target_frame_parser_unit import dtfp_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // item channel
  input  logic                  push,
  output logic                  full,
  input  logic                  mode_i,
  input  logic [7:0]            rx_byte_i,
  // result channel
  output logic                  empty,
  input  logic                  pop,
  output logic [1:0]            status_o,
  output logic                  black_valid_o,
  output logic signed [8:0]     black_x_o,
  output logic signed [8:0]     black_y_o,
  output logic                  car_valid_o,
  output logic signed [8:0]     car_x_o,
  output logic signed [8:0]     car_y_o,
  // config channel
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic [15:0] timeout_q;
  back_cfg_t   bcfg_q;

  logic ev_push, ev_full, ev_valid, ev_pop;
  ev_t  ev_in, ev_out;
  res_t res;

  // always ready: the user writes only while the block is idle; nothing enforces it
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q          <= TIMEOUT_RST;
      bcfg_q.x_center    <= X_CENTER_RST;
      bcfg_q.y_center    <= Y_CENTER_RST;
      bcfg_q.absent_code <= ABSENT_CODE_RST;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_TIMEOUT:  timeout_q          <= cfg_data_i[15:0];
        CFG_X_CENTER: bcfg_q.x_center    <= cfg_data_i[7:0];
        CFG_Y_CENTER: bcfg_q.y_center    <= cfg_data_i[7:0];
        CFG_ABSENT:   bcfg_q.absent_code <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  dtfp_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push            (push),
    .full            (full),
    .mode_i          (mode_i),
    .rx_byte_i       (rx_byte_i),
    .timeout_ticks_i (timeout_q),
    .ev_full_i       (ev_full),
    .ev_push_o       (ev_push),
    .ev_o            (ev_in)
  );

  dtfp_evq u_evq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (ev_push),
    .data_i  (ev_in),
    .full_o  (ev_full),
    .pop_i   (ev_pop),
    .valid_o (ev_valid),
    .data_o  (ev_out)
  );

  dtfp_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (bcfg_q),
    .ev_valid_i (ev_valid),
    .ev_i       (ev_out),
    .ev_pop_o   (ev_pop),
    .pop        (pop),
    .empty      (empty),
    .res_o      (res)
  );

  assign status_o      = res.status;
  assign black_valid_o = res.black_valid;
  assign black_x_o     = res.black_x;
  assign black_y_o     = res.black_y;
  assign car_valid_o   = res.car_valid;
  assign car_x_o       = res.car_x;
  assign car_y_o       = res.car_y;

endmodule

>>> hw/rtl/dtfp_front.sv
// Front end: sync hunt, tick timeout and frame byte collection.
module dtfp_front import dtfp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic        mode_i,
  input  logic [7:0]  rx_byte_i,
  input  logic [15:0] timeout_ticks_i,
  input  logic        ev_full_i,
  output logic        ev_push_o,
  output ev_t         ev_o
);

  logic                       collecting_q, collecting_d;
  logic [CNT_W-1:0]           cnt_q, cnt_d;
  logic [15:0]                ticks_q, ticks_d;
  logic [KEPT_BYTES-1:0][7:0] frame_q, frame_d;

  logic             accept;
  logic [15:0]      ticks_inc;
  logic [CNT_W-1:0] cnt_inc;

  assign full   = ev_full_i;
  assign accept = push && !ev_full_i;

  assign ticks_inc = (ticks_q != 16'hFFFF) ? ticks_q + 16'd1 : ticks_q;
  assign cnt_inc   = cnt_q + CNT_W'(1);

  always_comb begin
    collecting_d = collecting_q;
    cnt_d        = cnt_q;
    ticks_d      = ticks_q;
    frame_d      = frame_q;
    ev_push_o    = 1'b0;
    ev_o.kind    = EV_FRAME;
    ev_o.bytes   = frame_q;
    if (accept) begin
      if (!collecting_q) begin
        if (mode_i) begin
          if (ticks_inc >= timeout_ticks_i) begin
            ticks_d   = '0;
            ev_push_o = 1'b1;
            ev_o.kind = EV_TIMEOUT;
          end else begin
            ticks_d = ticks_inc;
          end
        end else if (rx_byte_i == SYNC_BYTE) begin
          collecting_d = 1'b1;
          cnt_d        = '0;
          ticks_d      = '0;
        end
      end else if (!mode_i) begin
        for (int i = 0; i < KEPT_BYTES; i++) begin
          if (cnt_q == CNT_W'(i)) frame_d[i] = rx_byte_i;
        end
        cnt_d = cnt_inc;
        if (rx_byte_i == TERM_BYTE) begin
          // a terminator before the checksum byte marks a short frame, a later one a full frame
          ev_push_o = 1'b1;
          ev_o.kind = (cnt_q < CNT_W'(KEPT_BYTES)) ? EV_SHORT : EV_FRAME;
        end else if (cnt_inc >= CNT_W'(MAX_FRAME_BYTES)) begin
          ev_push_o = 1'b1;
          ev_o.kind = EV_NOTERM;
        end
        if (ev_push_o) begin
          collecting_d = 1'b0;
          cnt_d        = '0;
          ticks_d      = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      collecting_q <= 1'b0;
      cnt_q        <= '0;
      ticks_q      <= '0;
    end else begin
      collecting_q <= collecting_d;
      cnt_q        <= cnt_d;
      ticks_q      <= ticks_d;
    end
  end

  always_ff @(posedge clk_i) begin
    frame_q <= frame_d;
  end

endmodule

>>> hw/rtl/dtfp_evq.sv
// Two-entry event queue between front and back.
module dtfp_evq import dtfp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  ev_t  data_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output ev_t  data_o
);

  ev_t        mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] count_q;
  logic       do_push, do_pop;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= 1'b0;
      rd_q    <= 1'b0;
      count_q <= 2'd0;
    end else begin
      if (do_push) wr_q <= !wr_q;
      if (do_pop)  rd_q <= !rd_q;
      count_q <= count_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= data_i;
  end

endmodule

>>> hw/rtl/dtfp_back.sv
// Back end: checksum, target update and two-entry result queue.
module dtfp_back import dtfp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  back_cfg_t cfg_i,
  input  logic      ev_valid_i,
  input  ev_t       ev_i,
  output logic      ev_pop_o,
  input  logic      pop,
  output logic      empty,
  output res_t      res_o
);

  logic              bv_q, bv_d, cv_q, cv_d;
  logic signed [8:0] bx_q, bx_d, by_q, by_d, cx_q, cx_d, cy_q, cy_d;

  res_t       oq_q [2];
  logic       wr_q, rd_q;
  logic [1:0] count_q;
  logic       oq_full, fire, do_pop;

  logic [5:0]        sum;
  logic              sum_ok, black_seen, car_seen;
  logic signed [8:0] bx_new, by_new, cx_new, cy_new;
  status_e           status;

  assign oq_full  = (count_q == 2'd2);
  assign empty    = (count_q == 2'd0);
  assign fire     = ev_valid_i && !oq_full;
  assign ev_pop_o = fire;
  assign do_pop   = pop && !empty;
  assign res_o    = oq_q[rd_q];

  assign sum = 6'(mod10(ev_i.bytes[0])) + 6'(mod10(ev_i.bytes[1]))
             + 6'(mod10(ev_i.bytes[2])) + 6'(mod10(ev_i.bytes[3]));
  assign sum_ok = (ev_i.bytes[DATA_BYTES] == {2'b00, sum});

  assign black_seen = (ev_i.bytes[0] != cfg_i.absent_code)
                   && (ev_i.bytes[1] != cfg_i.absent_code);
  assign car_seen   = (ev_i.bytes[2] != cfg_i.absent_code)
                   && (ev_i.bytes[3] != cfg_i.absent_code);

  assign bx_new = $signed({1'b0, ev_i.bytes[0]}) - $signed({1'b0, cfg_i.x_center});
  assign by_new = $signed({1'b0, ev_i.bytes[1]}) - $signed({1'b0, cfg_i.y_center});
  assign cx_new = $signed({1'b0, ev_i.bytes[2]}) - $signed({1'b0, cfg_i.x_center});
  assign cy_new = $signed({1'b0, ev_i.bytes[3]}) - $signed({1'b0, cfg_i.y_center});

  always_comb begin
    bv_d = bv_q; bx_d = bx_q; by_d = by_q;
    cv_d = cv_q; cx_d = cx_q; cy_d = cy_q;
    status = ST_SUM;
    case (ev_i.kind)
      EV_TIMEOUT: status = ST_TIMEOUT;
      EV_NOTERM:  status = ST_NOTERM;
      EV_SHORT:   status = ST_SUM;
      EV_FRAME:   status = sum_ok ? ST_OK : ST_SUM;
      default:    status = ST_SUM;
    endcase
    if (status == ST_OK) begin
      bv_d = black_seen;
      cv_d = car_seen;
      if (black_seen) begin
        bx_d = bx_new;
        by_d = by_new;
      end
      if (car_seen) begin
        cx_d = cx_new;
        cy_d = cy_new;
      end
    end else begin
      bv_d = 1'b0;
      cv_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bv_q <= 1'b0; bx_q <= '0; by_q <= '0;
      cv_q <= 1'b0; cx_q <= '0; cy_q <= '0;
      wr_q    <= 1'b0;
      rd_q    <= 1'b0;
      count_q <= 2'd0;
    end else begin
      if (fire) begin
        bv_q <= bv_d; bx_q <= bx_d; by_q <= by_d;
        cv_q <= cv_d; cx_q <= cx_d; cy_q <= cy_d;
        wr_q <= !wr_q;
      end
      if (do_pop) rd_q <= !rd_q;
      count_q <= count_q + {1'b0, fire} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      oq_q[wr_q] <= '{status: status, black_valid: bv_d, black_x: bx_d, black_y: by_d,
                      car_valid: cv_d, car_x: cx_d, car_y: cy_d};
    end
  end

endmodule

>>> hw/rtl/dtfp_checker.sv
// Port-level checks for the dual target frame parser, bound to the top level.
module dtfp_checker import dtfp_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  empty,
  input logic                  pop,
  input logic [1:0]            status_o,
  input logic                  black_valid_o,
  input logic signed [8:0]     black_x_o,
  input logic signed [8:0]     black_y_o,
  input logic                  car_valid_o,
  input logic signed [8:0]     car_x_o,
  input logic signed [8:0]     car_y_o
);

  // coordinates of the last result beat taken; all beats are taken in order,
  // so a target that did not load must show these again
  logic              seen_q;
  logic signed [8:0] bx_q, by_q, cx_q, cy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= 1'b0;
      bx_q   <= '0;
      by_q   <= '0;
      cx_q   <= '0;
      cy_q   <= '0;
    end else if (pop && !empty) begin
      seen_q <= 1'b1;
      bx_q   <= black_x_o;
      by_q   <= black_y_o;
      cx_q   <= car_x_o;
      cy_q   <= car_y_o;
    end
  end

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(status_o) && $stable(black_x_o)
                          && $stable(car_y_o) && $stable(black_valid_o)))
    else $error("result changed while stalled");

  a_fail_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && status_o != ST_OK) |-> (!black_valid_o && !car_valid_o))
    else $error("failed beat shows a valid target");

  a_black_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && seen_q && !black_valid_o) |-> (black_x_o == bx_q && black_y_o == by_q))
    else $error("black coordinates changed without a load");

  a_car_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && seen_q && !car_valid_o) |-> (car_x_o == cx_q && car_y_o == cy_q))
    else $error("car coordinates changed without a load");

endmodule

bind dual_target_frame_parser_unit dtfp_checker u_dtfp_checker (.*);
